FILE: src/qws_pkg.sv
// ----------------------------------------------------------------------------
// qws_pkg: shared types and constants of the quoted word splitter
// Result kinds, character codes, escape table and result queue sizing.
// ----------------------------------------------------------------------------
package qws_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE       = 2'd0;
  localparam logic [1:0] KIND_TOKEN_END  = 2'd1;
  localparam logic [1:0] KIND_STRING_END = 2'd2;

  // characters with a special meaning
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_DQUOTE    = 8'd34;
  localparam logic [7:0] CH_SQUOTE    = 8'd39;
  localparam logic [7:0] CH_BACKSLASH = 8'd92;
  localparam logic [7:0] CH_ZERO      = 8'd48;
  localparam logic [7:0] CH_NINE      = 8'd57;

  // escape letters and the bytes they stand for
  localparam logic [7:0] CH_B = 8'd98;
  localparam logic [7:0] CH_E = 8'd101;
  localparam logic [7:0] CH_F = 8'd102;
  localparam logic [7:0] CH_N = 8'd110;
  localparam logic [7:0] CH_R = 8'd114;
  localparam logic [7:0] CH_T = 8'd116;
  localparam logic [7:0] CH_V = 8'd118;

  localparam logic [7:0] ESC_BS  = 8'd8;
  localparam logic [7:0] ESC_ESC = 8'd27;
  localparam logic [7:0] ESC_FF  = 8'd12;
  localparam logic [7:0] ESC_LF  = 8'd10;
  localparam logic [7:0] ESC_CR  = 8'd13;
  localparam logic [7:0] ESC_TAB = 8'd9;
  localparam logic [7:0] ESC_VT  = 8'd11;

  // register map: byte address bit that selects the register
  localparam logic REG_DELIMITER = 1'b0;
  localparam logic REG_EMPTY_TOK = 1'b1;

  // result queue
  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } res_t;

  // space, tab, line feed, vertical tab, form feed, carriage return
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

FILE: src/quoted_word_splitter.sv
// ----------------------------------------------------------------------------
// quoted_word_splitter: shell-style word splitting with quotes and escapes
// Splits a byte stream into token bytes, token-end and string-end results.
// ----------------------------------------------------------------------------
// One input byte is accepted per cycle whenever the 8-entry result queue has
// room for four results; the byte is decoded in the cycle it is accepted and
// its 0 to 4 results are written into the queue at once. Results leave the
// queue one per cycle while out_ready is high, so the sustained rate is one
// byte per cycle as long as bytes average at most one result and out_ready
// stays high; the queue absorbs the extra results of bytes with more results.
// Configuration goes through a small APB port: delimiter at address 0 (zero
// means any whitespace), the empty-token flag at 4.
module quoted_word_splitter (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  input  logic       in_is_final,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_value,
  output logic       out_run_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    MODE_SKIP,
    MODE_TOKEN,
    MODE_SQUOTE,
    MODE_ESC,
    MODE_ESC0
  } mode_t;

  // parser state
  mode_t      mode_r, mode_nxt;
  logic       dq_r, dq_nxt;
  logic       dc_r, dc_nxt;
  logic [6:0] dv_r, dv_nxt;
  logic       thc_r, thc_nxt;

  // configuration
  logic [7:0] delim_r;
  logic       keep_r;

  // result queue
  qws_pkg::res_t                 fifo_r [qws_pkg::QUEUE_DEPTH];
  logic [qws_pkg::PTR_W-1:0]     wr_r, rd_r;
  logic [qws_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  logic                          in_fire, pop, cfg_wr;
  qws_pkg::res_t                 res [qws_pkg::MAX_RESULTS];
  logic [qws_pkg::NRES_W-1:0]    nres;

  assign in_fire = in_valid && in_ready;
  assign pop     = out_valid && out_ready;
  assign cfg_wr  = psel && penable && pwrite && pready;

  // configuration read and write
  assign pready = 1'b1;
  assign prdata = (paddr[2] == qws_pkg::REG_EMPTY_TOK) ? {31'd0, keep_r} : {24'd0, delim_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= 8'd0;
      keep_r  <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == qws_pkg::REG_EMPTY_TOK) begin
        keep_r <= pwdata[0];
      end else begin
        delim_r <= pwdata[7:0];
      end
    end
  end

  // byte decode: next state and the results of this byte
  always_comb begin
    logic [7:0] c;
    logic       do_tok;
    logic       delim_hit;
    logic [7:0] digit;
    logic [6:0] two_digit;

    c         = in_byte_in;
    do_tok    = 1'b0;
    digit     = c - qws_pkg::CH_ZERO;
    two_digit = {dv_r[3:0], 3'b000} + {dv_r[5:0], 1'b0} + digit[6:0];
    delim_hit = (delim_r != 8'd0) ? (c == delim_r) : qws_pkg::is_ws(c);

    mode_nxt = mode_r;
    dq_nxt   = dq_r;
    dc_nxt   = dc_r;
    dv_nxt   = dv_r;
    thc_nxt  = thc_r;
    nres     = '0;
    for (int k = 0; k < qws_pkg::MAX_RESULTS; k++) begin
      res[k] = '0;
    end

    // per-mode handling
    case (mode_r)
      MODE_SKIP: begin
        if (!qws_pkg::is_ws(c)) begin
          mode_nxt = MODE_TOKEN;
          thc_nxt  = 1'b0;
          dq_nxt   = 1'b0;
          do_tok   = 1'b1;
        end
      end
      MODE_SQUOTE: begin
        if (c == qws_pkg::CH_SQUOTE) begin
          mode_nxt = MODE_TOKEN;
        end else begin
          res[nres[1:0]] = '{qws_pkg::KIND_BYTE, c, 1'b0};
          nres    = nres + 1'b1;
          thc_nxt = 1'b1;
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_TOKEN;
        thc_nxt  = 1'b1;
        case (c)
          qws_pkg::CH_BACKSLASH: res[0] = '{qws_pkg::KIND_BYTE, qws_pkg::CH_BACKSLASH, 1'b0};
          qws_pkg::CH_B:         res[0] = '{qws_pkg::KIND_BYTE, qws_pkg::ESC_BS, 1'b0};
          qws_pkg::CH_E:         res[0] = '{qws_pkg::KIND_BYTE, qws_pkg::ESC_ESC, 1'b0};
          qws_pkg::CH_F:         res[0] = '{qws_pkg::KIND_BYTE, qws_pkg::ESC_FF, 1'b0};
          qws_pkg::CH_N:         res[0] = '{qws_pkg::KIND_BYTE, qws_pkg::ESC_LF, 1'b0};
          qws_pkg::CH_R:         res[0] = '{qws_pkg::KIND_BYTE, qws_pkg::ESC_CR, 1'b0};
          qws_pkg::CH_T:         res[0] = '{qws_pkg::KIND_BYTE, qws_pkg::ESC_TAB, 1'b0};
          qws_pkg::CH_V:         res[0] = '{qws_pkg::KIND_BYTE, qws_pkg::ESC_VT, 1'b0};
          qws_pkg::CH_SPACE:     res[0] = '{qws_pkg::KIND_BYTE, qws_pkg::CH_SPACE, 1'b0};
          qws_pkg::CH_DQUOTE:    res[0] = '{qws_pkg::KIND_BYTE, qws_pkg::CH_DQUOTE, 1'b0};
          qws_pkg::CH_ZERO: begin
            mode_nxt = MODE_ESC0;
            dc_nxt   = 1'b0;
            dv_nxt   = 7'd0;
            thc_nxt  = thc_r;
          end
          default: begin
            // unknown escape keeps the backslash
            res[0] = '{qws_pkg::KIND_BYTE, qws_pkg::CH_BACKSLASH, 1'b0};
            res[1] = '{qws_pkg::KIND_BYTE, c, 1'b0};
            nres   = nres + 1'b1;
          end
        endcase
        if (c != qws_pkg::CH_ZERO) begin
          nres = nres + 1'b1;
        end
      end
      MODE_ESC0: begin
        if ((c >= qws_pkg::CH_ZERO) && (c <= qws_pkg::CH_NINE)) begin
          if (!dc_r) begin
            dv_nxt = digit[6:0];
            dc_nxt = 1'b1;
          end else begin
            res[0]   = '{qws_pkg::KIND_BYTE, {1'b0, two_digit}, 1'b0};
            nres     = nres + 1'b1;
            thc_nxt  = 1'b1;
            mode_nxt = MODE_TOKEN;
            dc_nxt   = 1'b0;
            dv_nxt   = 7'd0;
          end
        end else begin
          // non-digit ends the number, then is parsed as usual
          res[0]   = '{qws_pkg::KIND_BYTE, {1'b0, dv_r}, 1'b0};
          nres     = nres + 1'b1;
          thc_nxt  = 1'b1;
          mode_nxt = MODE_TOKEN;
          dc_nxt   = 1'b0;
          dv_nxt   = 7'd0;
          do_tok   = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_TOKEN;
        do_tok   = 1'b1;
      end
    endcase

    // ordinary byte inside a token
    if (do_tok) begin
      if ((c == qws_pkg::CH_SQUOTE) && !dq_nxt) begin
        mode_nxt = MODE_SQUOTE;
      end else if (c == qws_pkg::CH_DQUOTE) begin
        dq_nxt = !dq_nxt;
      end else if (!dq_nxt && delim_hit) begin
        if (keep_r || thc_nxt) begin
          res[nres[1:0]] = '{qws_pkg::KIND_TOKEN_END, 8'd0, 1'b0};
          nres = nres + 1'b1;
        end
        mode_nxt = MODE_SKIP;
        thc_nxt  = 1'b0;
        dq_nxt   = 1'b0;
      end else if (c == qws_pkg::CH_BACKSLASH) begin
        mode_nxt = MODE_ESC;
      end else begin
        res[nres[1:0]] = '{qws_pkg::KIND_BYTE, c, 1'b0};
        nres    = nres + 1'b1;
        thc_nxt = 1'b1;
      end
    end

    // end of string: flush pending number, close token, mark string end
    if (in_is_final) begin
      if (mode_nxt == MODE_ESC0) begin
        res[nres[1:0]] = '{qws_pkg::KIND_BYTE, {1'b0, dv_nxt}, 1'b0};
        nres    = nres + 1'b1;
        thc_nxt = 1'b1;
      end
      if ((mode_nxt != MODE_SKIP) && (keep_r || thc_nxt)) begin
        res[nres[1:0]] = '{qws_pkg::KIND_TOKEN_END, 8'd0, 1'b0};
        nres = nres + 1'b1;
      end
      res[nres[1:0]] = '{qws_pkg::KIND_STRING_END, 8'd0, 1'b0};
      nres     = nres + 1'b1;
      mode_nxt = MODE_SKIP;
      dq_nxt   = 1'b0;
      dc_nxt   = 1'b0;
      dv_nxt   = 7'd0;
      thc_nxt  = 1'b0;
    end

    // mark the last result of this byte
    if (nres != '0) begin
      res[2'(nres - 1'b1)].last = 1'b1;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SKIP;
      dq_r   <= 1'b0;
      dc_r   <= 1'b0;
      dv_r   <= 7'd0;
      thc_r  <= 1'b0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      dq_r   <= dq_nxt;
      dc_r   <= dc_nxt;
      dv_r   <= dv_nxt;
      thc_r  <= thc_nxt;
    end
  end

  // result queue: up to four writes, one read per cycle
  assign in_ready     = cnt_r <= qws_pkg::CNT_W'(qws_pkg::QUEUE_DEPTH - qws_pkg::MAX_RESULTS);
  assign out_valid    = cnt_r != '0;
  assign out_kind     = fifo_r[rd_r].kind;
  assign out_value    = fifo_r[rd_r].value;
  assign out_run_last = fifo_r[rd_r].last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) begin
      cnt_nxt = cnt_nxt + qws_pkg::CNT_W'(nres);
    end
    if (pop) begin
      cnt_nxt = cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        wr_r <= wr_r + qws_pkg::PTR_W'(nres);
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < qws_pkg::MAX_RESULTS; k++) begin
      if (in_fire && (qws_pkg::NRES_W'(k) < nres)) begin
        fifo_r[wr_r + qws_pkg::PTR_W'(k)] <= res[k];
      end
    end
  end

`ifndef ASSERT_OFF
  // queue never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= qws_pkg::CNT_W'(qws_pkg::QUEUE_DEPTH))
    else $error("result queue count above depth");

  // an accepted item always finds room for all of its results
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ({1'b0, cnt_r} + {1'b0, qws_pkg::CNT_W'(nres)})
      <= (qws_pkg::CNT_W + 1)'(qws_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // end of string returns the parser to its idle state
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_is_final |=> mode_r == MODE_SKIP && !dq_r && !thc_r && !dc_r)
    else $error("parser state not cleared after end of string");

  // a pending first digit exists only after backslash-zero
  a_digit_mode: assert property (@(posedge clk) disable iff (!rst_n)
    dc_r |-> mode_r == MODE_ESC0)
    else $error("digit count set outside numeric escape");
`endif

endmodule
